>>> rtl/lbh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lbh_pkg;

  localparam int BUCKET_DEPTH = 256;
  localparam int ADDR_W       = $clog2(BUCKET_DEPTH);

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int STEP_W   = 16;
  localparam int COUNT_W  = 8;
  localparam int INDEX_W  = 8;
  localparam int TOTAL_W  = 32;
  localparam int SUM_W    = 63;
  localparam int MAG_W    = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_RECORD = 2'd0,
    OP_READ   = 2'd1,
    OP_STATS  = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUCKET_STEP  = 1'd0,
    REG_BUCKET_COUNT = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic             upd;
    logic             clr;
    logic [MAG_W-1:0] value;
  } stats_cmd_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] count;
    logic [SUM_W-1:0]   sum;
    logic [MAG_W-1:0]   min;
    logic [MAG_W-1:0]   max;
  } stats_t;

endpackage

`default_nettype wire

>>> rtl/lbh_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lbh_in_if;
  import lbh_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic signed [VALUE_W-1:0] sample_value;
  logic [INDEX_W-1:0] bucket_index;

  modport source (output valid, output opcode, output sample_value, output bucket_index,
                  input ready);
  modport sink   (input valid, input opcode, input sample_value, input bucket_index,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/lbh_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lbh_out_if;
  import lbh_pkg::*;

  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] bucket_total;
  logic [TOTAL_W-1:0] samples_seen;
  logic [SUM_W-1:0]   value_total;
  logic [MAG_W-1:0]   smallest_value;
  logic [MAG_W-1:0]   largest_value;
  logic               bad_value;

  modport source (output valid, output bucket_total, output samples_seen,
                  output value_total, output smallest_value, output largest_value,
                  output bad_value, input ready);
  modport sink   (input valid, input bucket_total, input samples_seen,
                  input value_total, input smallest_value, input largest_value,
                  input bad_value, output ready);
endinterface

`default_nettype wire

>>> rtl/lbh_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/lbh_div.sv
`timescale 1ns / 1ps
`default_nettype none

module lbh_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [lbh_pkg::VALUE_W-1:0] dividend,
  input  wire logic [lbh_pkg::STEP_W-1:0]  divisor,
  output logic      [lbh_pkg::VALUE_W-1:0] quotient,
  output logic                             done
);
  import lbh_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W);

  logic [VALUE_W-1:0] shreg;
  logic [STEP_W-1:0]  dsr;
  logic [STEP_W-1:0]  rem;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [STEP_W:0]    trial;
  logic [STEP_W:0]    diff;
  logic               ge;

  assign trial    = {rem, shreg[VALUE_W-1]};
  assign diff     = trial - {1'b0, dsr};
  assign ge       = trial >= {1'b0, dsr};
  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      cnt   <= '0;
      shreg <= dividend;
      dsr   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      // shift one dividend bit into the remainder, one quotient bit out
      rem   <= ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
      shreg <= {shreg[VALUE_W-2:0], ge};
      cnt   <= cnt + 1'b1;
      if (cnt == CNT_W'(VALUE_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lbh_stats.sv
`timescale 1ns / 1ps
`default_nettype none

module lbh_stats (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lbh_pkg::stats_cmd_t cmd,
  output lbh_pkg::stats_t          stats
);
  import lbh_pkg::*;

  logic [SUM_W:0] sum_ext;
  stats_t         stats_next;

  assign sum_ext = {1'b0, stats.sum} + {{(SUM_W + 1 - MAG_W){1'b0}}, cmd.value};

  always_comb begin
    stats_next       = stats;
    stats_next.sum   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    stats_next.count = (stats.count == '1) ? stats.count : stats.count + 1'b1;
    if (stats.count == '0) begin
      stats_next.min = cmd.value;
      stats_next.max = cmd.value;
    end else begin
      if (cmd.value < stats.min) begin
        stats_next.min = cmd.value;
      end
      if (cmd.value > stats.max) begin
        stats_next.max = cmd.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      stats <= '0;
    end else if (cmd.upd) begin
      stats <= stats_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/linear_bucket_histogram_top.sv
// Record: accept starts the bit-serial divider, which takes one quotient bit per cycle;
//   then one bucket read and one write-back on the bucket RAM, then the output register.
//   A new item is taken only once the previous one has reached the output register.
// Read bucket: read, update, then output state; read statistics and clear: output state only.
// A new word is taken while the previous result still waits in the output register.
// Synchronous reset: empties all buckets at once, clears statistics, sets step 1, count 255.
`timescale 1ns / 1ps
`default_nettype none

module linear_bucket_histogram_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  lbh_in_if.sink                               sample_in,
  lbh_out_if.source                            result_out,
  input  wire logic                            cfg_we,
  input  wire logic [lbh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lbh_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lbh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_UPD,
    S_OUT
  } state_t;

  state_t                  state;
  opcode_t                 op_q;
  logic                    neg_q;
  logic [MAG_W-1:0]        mag_q;
  logic [INDEX_W-1:0]      idx_q;
  logic [ADDR_W-1:0]       addr_q;
  logic [TOTAL_W-1:0]      total_q;
  logic [STEP_W-1:0]       step_q;
  logic [COUNT_W-1:0]      count_q;
  logic [BUCKET_DEPTH-1:0] bkt_valid;
  logic                    vld_q;

  logic                    accept;
  opcode_t                 in_op;
  logic [STEP_W-1:0]       step_eff;
  logic [VALUE_W:0]        num;
  logic [VALUE_W:0]        num_neg;
  logic [VALUE_W-1:0]      mag;
  logic                    num_neg_q;
  logic [ADDR_W-1:0]       top_idx;
  logic [VALUE_W-1:0]      quo;
  logic                    div_done;
  logic [ADDR_W-1:0]       bkt_sel;
  logic [TOTAL_W-1:0]      ram_q;
  logic [TOTAL_W-1:0]      rd_data;
  logic [TOTAL_W-1:0]      inc_data;
  logic                    ram_we;
  stats_cmd_t              cmd;
  stats_t                  stats;

  assign accept   = sample_in.valid && sample_in.ready;
  assign in_op    = opcode_t'(sample_in.opcode);
  assign sample_in.ready = (state == S_IDLE);

  assign step_eff = (step_q == '0) ? STEP_W'(1) : step_q;
  assign num      = {sample_in.sample_value[VALUE_W-1], sample_in.sample_value}
                    + {{(VALUE_W + 1 - STEP_W){1'b0}}, step_eff} - (VALUE_W + 1)'(1);
  assign num_neg  = -num;
  assign mag      = num[VALUE_W] ? num_neg[VALUE_W-1:0] : num[VALUE_W-1:0];

  assign top_idx  = (32'(count_q) >= BUCKET_DEPTH) ? ADDR_W'(BUCKET_DEPTH - 1)
                                                   : ADDR_W'(count_q);

  always_comb begin
    if (num_neg_q) begin
      bkt_sel = (quo == '0) ? '0 : top_idx;
    end else if (quo > VALUE_W'(top_idx)) begin
      bkt_sel = top_idx;
    end else begin
      bkt_sel = ADDR_W'(quo);
    end
  end

  assign rd_data  = vld_q ? ram_q : '0;
  assign inc_data = (rd_data == '1) ? rd_data : rd_data + 1'b1;
  assign ram_we   = (state == S_UPD) && (op_q == OP_RECORD);

  assign cmd.upd   = ram_we && !neg_q;
  assign cmd.clr   = accept && (in_op == OP_CLEAR);
  assign cmd.value = mag_q;

  lbh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && (in_op == OP_RECORD)),
    .dividend (mag),
    .divisor  (step_eff),
    .quotient (quo),
    .done     (div_done)
  );

  lbh_ram #(
    .WIDTH (TOTAL_W),
    .DEPTH (BUCKET_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_q),
    .wdata (inc_data),
    .raddr (addr_q),
    .rdata (ram_q)
  );

  lbh_stats u_stats (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .stats (stats)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step_q  <= STEP_W'(1);
      count_q <= COUNT_W'(255);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BUCKET_STEP:  step_q  <= cfg_data[STEP_W-1:0];
        REG_BUCKET_COUNT: count_q <= cfg_data[COUNT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      bkt_valid <= '0;
    end else if (ram_we) begin
      bkt_valid[addr_q] <= 1'b1;
    end
    vld_q <= bkt_valid[addr_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      result_out.valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q      <= in_op;
            neg_q     <= sample_in.sample_value[VALUE_W-1];
            mag_q     <= sample_in.sample_value[MAG_W-1:0];
            idx_q     <= sample_in.bucket_index;
            addr_q    <= ADDR_W'(sample_in.bucket_index);
            num_neg_q <= num[VALUE_W];
            total_q   <= '0;
            unique case (in_op)
              OP_RECORD: state <= S_DIV;
              OP_READ:   state <= S_RD;
              OP_STATS:  state <= S_OUT;
              OP_CLEAR:  state <= S_OUT;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            addr_q <= bkt_sel;
            state  <= S_RD;
          end
        end
        S_RD: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (op_q == OP_RECORD) begin
            total_q <= inc_data;
          end else if (32'(idx_q) < BUCKET_DEPTH) begin
            total_q <= rd_data;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!result_out.valid || result_out.ready) begin
            result_out.bucket_total   <= total_q;
            result_out.samples_seen   <= stats.count;
            result_out.value_total    <= stats.sum;
            result_out.smallest_value <= stats.min;
            result_out.largest_value  <= stats.max;
            result_out.bad_value      <= (op_q == OP_RECORD) && neg_q;
            result_out.valid          <= 1'b1;
            state                     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state != S_OUT && result_out.valid && result_out.ready) begin
        result_out.valid <= 1'b0;
      end
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !sample_in.ready)
    else $error("input taken while an item is in flight");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (addr_q <= top_idx))
    else $error("bucket write beyond overflow bucket");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clr |=> (bkt_valid == '0) && (stats.count == '0) && (stats.sum == '0))
    else $error("clear left buckets or statistics behind");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_out.valid) |-> $past(state == S_OUT))
    else $error("result raised outside the output state");

endmodule

`default_nettype wire
